// ===== hw/rtl/svt_pkg.sv =====
// Package for the sorted value table: sizes, status codes and the cell command struct.
package svt_pkg;

	localparam int Depth = 16;
	localparam int CntW = $clog2(Depth + 1);

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StFull     = 2'd1;
	localparam logic [1:0] StEmpty    = 2'd2;
	localparam logic [1:0] StNotFound = 2'd3;

	localparam logic CmdInsert = 1'b0;
	localparam logic CmdDelete = 1'b1;

	typedef struct packed {
		logic               ins;   // insert shifts right from the slot
		logic               del;   // delete of a present value shifts left
		logic signed [31:0] key;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/svt_cell.sv =====
// One slot of the sorted row: holds a value, compares it to the key, shifts with neighbors.
module svt_cell (
	input  logic                clk,
	input  svt_pkg::cell_cmd_t  cmd,
	input  logic                slot_valid,
	input  logic signed [31:0]  left_value,
	input  logic                left_lt,
	input  logic signed [31:0]  right_value,
	output logic signed [31:0]  value,
	output logic                lt,
	output logic                eq
);
	import svt_pkg::*;

	logic signed [31:0] value_q;

	assign value = value_q;
	assign lt    = slot_valid && (value_q < cmd.key);
	assign eq    = slot_valid && (value_q == cmd.key);

	always_ff @(posedge clk) begin
		if (cmd.ins && !lt) begin
			value_q <= left_lt ? cmd.key : left_value;
		end else if (cmd.del && !lt) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== hw/rtl/sorted_value_table.sv =====
// Top level of the sorted value table: a row of compare-and-shift cells plus result register.
//
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | command, value
//  out     | out_valid | out_ready | status, entry_count
//
// One transaction per cycle while in_ready is high: every cell compares against the key at once and
// shifts by one slot toward or away from its neighbor in the same cycle.
// The result sits in a register in the cycle after the input is accepted.
// in_ready is high while the result register is empty or being drained.
// Reset clears the count and the result valid; cell contents stay undefined.
module sorted_value_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [4:0]         entry_count
);
	import svt_pkg::*;

	logic [CntW-1:0]    count_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [4:0]         entry_count_q;

	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic               found;
	logic [1:0]         status_d;
	logic [CntW-1:0]    count_d;
	cell_cmd_t          cmd;

	logic signed [31:0] cell_value [Depth];
	logic [Depth-1:0]   cell_lt;
	logic [Depth-1:0]   cell_eq;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign is_full  = (count_q == CntW'(Depth));
	assign is_empty = (count_q == '0);
	assign found    = |cell_eq;

	assign cmd.key = value;
	assign cmd.ins = accept && (command == CmdInsert) && !is_full;
	assign cmd.del = accept && (command == CmdDelete) && found;

	for (genvar i = 0; i < Depth; i++) begin : g_cell
		svt_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.slot_valid  (count_q > CntW'(i)),
			.left_value  ((i == 0) ? value : cell_value[(i == 0) ? 0 : i - 1]),
			.left_lt     ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
			.right_value ((i == Depth - 1) ? value : cell_value[(i == Depth - 1) ? i : i + 1]),
			.value       (cell_value[i]),
			.lt          (cell_lt[i]),
			.eq          (cell_eq[i])
		);
	end

	always_comb begin
		status_d = StOk;
		count_d  = count_q;
		if (command == CmdInsert) begin
			if (is_full) begin
				status_d = StFull;
			end else begin
				count_d = count_q + CntW'(1);
			end
		end else if (is_empty) begin
			status_d = StEmpty;
		end else if (!found) begin
			status_d = StNotFound;
		end else begin
			count_d = count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			entry_count_q <= 5'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("count above depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && (entry_count_q == 5'(count_q)))
		else $error("result does not match count");

	a_ok_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (status_d == StOk) |=> count_q != $past(count_q))
		else $error("ok result without count change");

	a_refuse_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (status_d != StOk) |=> count_q == $past(count_q))
		else $error("refused item changed count");

endmodule

// ===== bench/tb_sorted_value_table.sv =====
// Testbench for sorted_value_table: ordered insert/delete checked against a shadow table.
`timescale 1ns / 100ps

module tb_sorted_value_table;
	import svt_pkg::*;

	localparam int WatchdogLimit = 1000;
	localparam int HoldCycles    = 80;
	localparam int DrainCycles   = 8;

	typedef struct {
		logic [1:0] status;
		logic [4:0] count;
	} table_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               command = CmdInsert;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [4:0]         entry_count;

	logic signed [31:0] shadow_table[$];
	table_result_t      pending_results[$];
	table_result_t      oldest_result;
	logic signed [31:0] value_pool[6];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_req = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;
	int n_inserts = 0;
	int n_deletes = 0;
	int peak_count = 0;
	int holds_done = 0;
	int status_seen[4];

	sorted_value_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the table: ordered insert before the first entry not less than the value,
	// delete of the first equal entry.
	function automatic table_result_t table_update(input logic cmd, input logic signed [31:0] val);
		table_result_t r;
		int pos;
		pos = 0;
		if (cmd == CmdInsert) begin
			n_inserts++;
			if (shadow_table.size() >= Depth) begin
				r.status = StFull;
			end else begin
				while (pos < shadow_table.size() && shadow_table[pos] < val)
					pos++;
				shadow_table.insert(pos, val);
				r.status = StOk;
			end
		end else begin
			n_deletes++;
			if (shadow_table.size() == 0) begin
				r.status = StEmpty;
			end else begin
				while (pos < shadow_table.size() && shadow_table[pos] != val)
					pos++;
				if (pos >= shadow_table.size()) begin
					r.status = StNotFound;
				end else begin
					shadow_table.delete(pos);
					r.status = StOk;
				end
			end
		end
		r.count = 5'(shadow_table.size());
		status_seen[r.status]++;
		if (shadow_table.size() > peak_count)
			peak_count = shadow_table.size();
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, act_v);
	endtask

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_item(input logic cmd, input logic signed [31:0] val);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_results.push_back(table_update(cmd, val));
	endtask

	task automatic test_corner_values();
		send_item(CmdDelete, 32'sd0);
		send_item(CmdInsert, 32'h8000_0000);
		send_item(CmdInsert, 32'h7fff_ffff);
		send_item(CmdInsert, 32'sd0);
		send_item(CmdInsert, -32'sd1);
		send_item(CmdInsert, 32'sd5);
		send_item(CmdInsert, 32'sd5);
		send_item(CmdDelete, 32'sd7);
		send_item(CmdDelete, 32'sd5);
		send_item(CmdDelete, 32'h8000_0000);
		send_item(CmdDelete, 32'h7fff_ffff);
	endtask

	task automatic test_full_table();
		int k;
		k = 0;
		while (shadow_table.size() < Depth) begin
			send_item(CmdInsert, k[0] ? 32'h7ffe_0000 + k : 32'h8001_0000 - k);
			k++;
		end
		send_item(CmdInsert, 32'sd3);
		send_item(CmdDelete, shadow_table[Depth - 1]);
	endtask

	task automatic test_random_traffic(input int n_items);
		int k;
		int regime;
		int roll;
		logic cmd;
		logic signed [31:0] val;
		regime = 2;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (k = 0; k < n_items; k++) begin
			if (k % 50 == 0) begin
				regime = $urandom_range(0, 2);
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
				value_pool[4] = $urandom;
				value_pool[5] = $urandom;
			end
			roll = $urandom_range(0, 99);
			case (regime)
				0: cmd = (roll < 75) ? CmdInsert : CmdDelete;
				1: cmd = (roll < 75) ? CmdDelete : CmdInsert;
				default: cmd = (roll < 50) ? CmdInsert : CmdDelete;
			endcase
			if (cmd == CmdDelete && shadow_table.size() != 0 && $urandom_range(0, 9) < 7) begin
				val = shadow_table[$urandom_range(0, shadow_table.size() - 1)];
			end else begin
				roll = $urandom_range(0, 9);
				if (roll < 5)
					val = value_pool[$urandom_range(0, 5)];
				else if (roll < 8)
					val = int'($urandom_range(0, 16)) - 8;
				else
					val = $urandom;
			end
			send_item(cmd, val);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Receiver stops draining while the sender keeps offering transactions.
	task automatic test_input_backpressure();
		int k;
		tx_idle = 1'b0;
		hold_req = 1'b1;
		for (k = 0; k < 24; k++)
			send_item($urandom_range(0, 1) ? CmdDelete : CmdInsert, value_pool[$urandom_range(0, 5)]);
		tx_idle = 1'b1;
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			stall = rx_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with none pending, status", -1, status);
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.status)
					note_mismatch("status", oldest_result.status, status);
				if (entry_count !== oldest_result.count)
					note_mismatch("entry_count", oldest_result.count, entry_count);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WatchdogLimit) begin
					$display("Watchdog: no transaction for %0d cycles", idle_cycles);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_full_table();
		test_random_traffic(610);
		test_input_backpressure();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Ran %0d inserts and %0d deletes; ok %0d, full %0d, empty %0d, not found %0d",
			n_inserts, n_deletes, status_seen[StOk], status_seen[StFull],
			status_seen[StEmpty], status_seen[StNotFound]);
		$display("Peak occupancy %0d of %0d, receiver hold-offs %0d, mismatches %0d",
			peak_count, Depth, holds_done, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
